>>> hw/rtl/delimited_field_extractor_top_assert.svh
// Assertion macros shared by the checker of the delimited field extractor.
// Included by fdx_checker.sv; needs nothing else.
`ifndef DELIMITED_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define DELIMITED_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define FDX_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fdx: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define FDX_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fdx: next-cycle check failed");

// Next-cycle implication that stays on through reset.
`define FDX_ASSERT_ALWAYS(name, clk, pre, post) \
   name: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("fdx: reset check failed");

`endif

>>> hw/rtl/fdx_pkg.sv
// Shared types and constants of the delimited field extractor.
// Used by every module of the block; depends on nothing.
package fdx_pkg;

   localparam int DATA_W     = 8;
   localparam int CFG_W      = 64;
   localparam int LEN_W      = 6;
   localparam int REG_COUNT  = 5;
   localparam int CSR_ADDR_W = $clog2(8 * REG_COUNT);
   localparam int REG_IDX_W  = CSR_ADDR_W - 3;
   localparam int JOB_DEPTH  = 4;

   localparam logic [REG_IDX_W-1:0] REG_START_PATTERN = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_START_LENGTH  = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_END_PATTERN   = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_END_LENGTH    = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_MAX_FIELD     = REG_IDX_W'(4);

   localparam logic [5:0] MAX_FIELD_RESET = 6'd32;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic              result_type;
      logic [DATA_W-1:0] field_byte;
      logic              status;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] start_pattern;
      logic [3:0]       start_length;
      logic [CFG_W-1:0] end_pattern;
      logic [3:0]       end_length;
      logic [5:0]       max_field_length;
   } cfg_type;

   // One finished string: either a failure, or a success whose field of len
   // bytes sits in the given bank of the field memory.
   typedef struct packed {
      logic             ok;
      logic [LEN_W-1:0] len;
      logic             bank;
   } job_type;

   // The back end is done reading a bank.
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

>>> hw/rtl/fdx_job_queue.sv
// Short queue of finished-string jobs between the front and back ends.
// Depends on fdx_pkg.
module fdx_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fdx_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output fdx_pkg::job_type head_job
);
   import fdx_pkg::*;

   localparam int PW = $clog2(JOB_DEPTH);
   localparam int NW = $clog2(JOB_DEPTH + 1);

   job_type        slot_ff [JOB_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  count_ff, count_in;
   logic           do_pop;

   assign full       = (count_ff == NW'(JOB_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + NW'(push) - NW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/fdx_front.sv
// Front end: takes source bytes, tracks the delimiters, stores field bytes
// and turns each finished string into a job. Depends on fdx_pkg.
module fdx_front #(
   parameter int DELIM_MAX = 8,
   parameter int FIELD_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fdx_pkg::cfg_type     cfg,
   input  logic                 req_push,
   input  fdx_pkg::req_type     req_data,
   output logic                 req_full,
   input  logic                 job_full,
   output logic                 job_push,
   output fdx_pkg::job_type     job_data,
   input  fdx_pkg::release_type bank_release,
   output logic                 mem_wr_en,
   output logic [$clog2(2*(FIELD_MAX+DELIM_MAX))-1:0] mem_wr_addr,
   output logic [7:0]           mem_wr_data
);
   import fdx_pkg::*;

   localparam int BUF_DEPTH = FIELD_MAX + DELIM_MAX;
   localparam int MEM_AW    = $clog2(2 * BUF_DEPTH);
   localparam int CW        = $clog2(BUF_DEPTH + 1);
   localparam int SW        = $clog2(DELIM_MAX + 1);
   localparam int CMPW      = (CW + 1 > 8) ? CW + 1 : 8;

   localparam logic [1:0] PH_SEEK    = 2'd0;
   localparam logic [1:0] PH_COLLECT = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic [SW-1:0] seen_ff, seen_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    win_ff [DELIM_MAX];
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;

   logic [7:0]      win_s [DELIM_MAX];
   logic [SW-1:0]   base_seen, seen_s;
   logic [CW-1:0]   base_cnt, cnt1;
   logic [CFG_W-1:0] mpat;
   logic [3:0]      mlen;
   logic [DELIM_MAX:1] eq_len;
   logic            match;
   logic            in_seek, use_start, start_hit, p1_collect, do_collect;
   logic            el_zero, el_big, cnt_room;
   logic [5:0]      maxlen;
   logic [CMPW-1:0] cnt1_w, el_w, max_w, len_w;
   logic            len_ok, end_hit, over, fin_ok0, finished, last_fail;
   logic            accept, claim, shift_win;

   assign accept   = req_push && !req_full;
   assign req_full = job_full || busy_ff[bank_ff];

   assign in_seek   = (phase_ff == PH_SEEK);
   assign use_start = in_seek && (cfg.start_length != 4'd0);
   assign el_zero   = (cfg.end_length == 4'd0);
   assign el_big    = (cfg.end_length > 4'(DELIM_MAX));
   assign maxlen    = (cfg.max_field_length > 6'(FIELD_MAX)) ? 6'(FIELD_MAX)
                                                             : cfg.max_field_length;

   // An empty start delimiter drops straight into collecting with a fresh
   // window, so the byte shifts into an empty window.
   assign base_seen = (in_seek && !use_start) ? '0 : seen_ff;
   assign base_cnt  = in_seek ? '0 : cnt_ff;
   assign seen_s    = (base_seen == SW'(DELIM_MAX)) ? base_seen : base_seen + 1'b1;

   always_comb begin
      win_s[0] = req_data.data_byte;
      for (int i = 1; i < DELIM_MAX; i++) begin
         win_s[i] = win_ff[i-1];
      end
   end

   // One shared matcher: start delimiter while one is sought, else the end.
   assign mpat = use_start ? cfg.start_pattern : cfg.end_pattern;
   assign mlen = use_start ? cfg.start_length : cfg.end_length;

   always_comb begin
      for (int l = 1; l <= DELIM_MAX; l++) begin
         eq_len[l] = 1'b1;
         for (int j = 0; j < l; j++) begin
            if (mpat[8*j +: 8] != win_s[l-1-j]) begin
               eq_len[l] = 1'b0;
            end
         end
      end
      match = 1'b0;
      for (int l = 1; l <= DELIM_MAX; l++) begin
         if (mlen == 4'(l) && eq_len[l] && seen_s >= SW'(l)) begin
            match = 1'b1;
         end
      end
   end

   assign start_hit  = use_start && match;
   assign p1_collect = (in_seek && (!use_start || start_hit)) || (phase_ff == PH_COLLECT);
   assign do_collect = p1_collect && !el_zero && !use_start;

   assign cnt_room = (base_cnt < CW'(BUF_DEPTH));
   assign cnt1     = cnt_room ? base_cnt + 1'b1 : base_cnt;

   assign cnt1_w = CMPW'(cnt1);
   assign el_w   = CMPW'(cfg.end_length);
   assign max_w  = CMPW'(maxlen);
   assign len_w  = cnt1_w - el_w;
   assign len_ok = (len_w <= max_w);

   assign fin_ok0   = p1_collect && el_zero;
   assign end_hit   = do_collect && !el_big && match;
   assign over      = do_collect && !el_big && !match &&
                      ((cnt1_w + 1'b1 > max_w + el_w) || (cnt1 == CW'(BUF_DEPTH)));
   assign finished  = fin_ok0 || end_hit || over;
   assign last_fail = req_data.is_last && !finished && (phase_ff != PH_DONE);

   always_comb begin
      job_data.ok   = fin_ok0 || (end_hit && len_ok);
      job_data.len  = (end_hit && len_ok) ? len_w[LEN_W-1:0] : '0;
      job_data.bank = bank_ff;
   end

   assign job_push = accept && (finished || last_fail);
   assign claim    = job_push && job_data.ok && (job_data.len != '0);

   assign mem_wr_en   = accept && do_collect && cnt_room;
   assign mem_wr_addr = bank_ff ? MEM_AW'(BUF_DEPTH) + MEM_AW'(base_cnt) : MEM_AW'(base_cnt);
   assign mem_wr_data = req_data.data_byte;
   assign shift_win   = accept && (use_start || do_collect);

   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         if (req_data.is_last) begin
            phase_in = PH_SEEK;
            seen_in  = '0;
            cnt_in   = '0;
         end else if (finished) begin
            phase_in = PH_DONE;
         end else if (p1_collect) begin
            phase_in = PH_COLLECT;
            seen_in  = do_collect ? seen_s : '0;
            cnt_in   = do_collect ? cnt1 : '0;
         end else if (use_start) begin
            seen_in = seen_s;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      if (claim) begin
         busy_in[bank_ff] = 1'b1;
      end
      bank_in = claim ? ~bank_ff : bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         seen_ff  <= '0;
         cnt_ff   <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         cnt_ff   <= cnt_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_win) begin
         win_ff <= win_s;
      end
   end

endmodule

>>> hw/rtl/fdx_back.sv
// Back end: holds the two-bank field memory and replays each job as field
// bytes and a status. Depends on fdx_pkg.
module fdx_back #(
   parameter int DELIM_MAX = 8,
   parameter int FIELD_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mem_wr_en,
   input  logic [$clog2(2*(FIELD_MAX+DELIM_MAX))-1:0] mem_wr_addr,
   input  logic [7:0]           mem_wr_data,
   input  logic                 job_valid,
   input  fdx_pkg::job_type     job_data,
   output logic                 job_pop,
   output fdx_pkg::release_type bank_release,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output fdx_pkg::rsp_type     rsp_data
);
   import fdx_pkg::*;

   localparam int BUF_DEPTH = FIELD_MAX + DELIM_MAX;
   localparam int MEM_AW    = $clog2(2 * BUF_DEPTH);

   logic [7:0]        mem [2*BUF_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [MEM_AW-1:0] rd_addr;

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_type_ff, s1_type_in;
   logic             s1_status_ff, s1_status_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;

   logic out_take, s2_load, s1_free, issue, issue_byte;

   assign out_take   = rsp_pop && out_valid_ff;
   assign s2_load    = s1_valid_ff && (!out_valid_ff || out_take);
   assign s1_free    = !s1_valid_ff || s2_load;
   assign issue      = job_valid && s1_free;
   assign issue_byte = job_data.ok && (idx_ff < job_data.len);

   assign rd_addr = job_data.bank ? MEM_AW'(BUF_DEPTH) + MEM_AW'(idx_ff) : MEM_AW'(idx_ff);

   assign job_pop            = issue && !issue_byte;
   assign bank_release.valid = job_pop && job_data.ok && (job_data.len != '0);
   assign bank_release.bank  = job_data.bank;

   always_comb begin
      idx_in       = idx_ff;
      s1_valid_in  = s2_load ? 1'b0 : s1_valid_ff;
      s1_type_in   = s1_type_ff;
      s1_status_in = s1_status_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
         if (issue_byte) begin
            idx_in       = idx_ff + 1'b1;
            s1_type_in   = 1'b0;
            s1_status_in = 1'b0;
         end else begin
            idx_in       = '0;
            s1_type_in   = 1'b1;
            s1_status_in = !job_data.ok;
         end
      end
   end

   always_comb begin
      out_valid_in = out_take ? 1'b0 : out_valid_ff;
      out_data_in  = out_data_ff;
      if (s2_load) begin
         out_valid_in            = 1'b1;
         out_data_in.result_type = s1_type_ff;
         out_data_in.field_byte  = s1_type_ff ? 8'd0 : rd_data_ff;
         out_data_in.status      = s1_status_ff;
         out_data_in.last_of_run = s1_type_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_type_ff   <= s1_type_in;
      s1_status_ff <= s1_status_in;
      out_data_ff  <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (issue && issue_byte) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> hw/rtl/delimited_field_extractor_top.sv
// Top level of the delimited field extractor: configuration registers, front end,
// job queue and back end. Depends on fdx_pkg, fdx_front, fdx_job_queue and fdx_back.
//
//   channel   ports                    handshake                 payload
//   request   req_push/req_full        beat on push & !full      fdx_pkg::req_type
//   response  rsp_empty/rsp_pop        beat on pop & !empty      fdx_pkg::rsp_type
//   config    psel/penable/pwrite/...  APB, pready tied high     64-bit registers
//
// One source byte is taken per cycle while req_full is low; the front end finishes
// it in that cycle. A success with k field bytes gives k + 1 response beats, one per
// cycle when popped; the first passes the job queue, read stage and output register.
// req_full rises while the four-entry job queue is full or while the bank the
// next string would write still holds a field the back end has not replayed.
// Reset is synchronous; field memory is read only where the same string wrote it.
module delimited_field_extractor_top #(
   parameter int DELIM_MAX = 8,
   parameter int FIELD_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request queue side.
   input  logic                                req_push,
   input  fdx_pkg::req_type                    req_data,
   output logic                                req_full,
   // Response queue side.
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output fdx_pkg::rsp_type                    rsp_data,
   // Register port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fdx_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fdx_pkg::CFG_W-1:0]           pwdata,
   output logic [fdx_pkg::CFG_W-1:0]           prdata,
   output logic                                pready
);
   import fdx_pkg::*;

   localparam int BUF_DEPTH = FIELD_MAX + DELIM_MAX;
   localparam int MEM_AW    = $clog2(2 * BUF_DEPTH);

   // Registers are 64 bits wide, so each takes an eight-byte slot.
   cfg_type              cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_write;

   logic        job_full, job_push, job_valid, job_pop;
   job_type     job_in_data, job_head;
   release_type bank_release;
   logic              mem_wr_en;
   logic [MEM_AW-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:3];
   assign csr_write = psel && penable && pwrite && pready;

   // Only the low bits a register holds are kept from the written word.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_START_PATTERN: cfg_in.start_pattern    = pwdata;
            REG_START_LENGTH:  cfg_in.start_length     = pwdata[3:0];
            REG_END_PATTERN:   cfg_in.end_pattern      = pwdata;
            REG_END_LENGTH:    cfg_in.end_length       = pwdata[3:0];
            REG_MAX_FIELD:     cfg_in.max_field_length = pwdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_PATTERN: prdata = cfg_ff.start_pattern;
         REG_START_LENGTH:  prdata = CFG_W'(cfg_ff.start_length);
         REG_END_PATTERN:   prdata = cfg_ff.end_pattern;
         REG_END_LENGTH:    prdata = CFG_W'(cfg_ff.end_length);
         REG_MAX_FIELD:     prdata = CFG_W'(cfg_ff.max_field_length);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_pattern:    '0,
                     start_length:     '0,
                     end_pattern:      '0,
                     end_length:       '0,
                     max_field_length: MAX_FIELD_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: delimiter search and field capture, one byte per cycle while req_full is low.
   fdx_front #(
      .DELIM_MAX (DELIM_MAX),
      .FIELD_MAX (FIELD_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .job_full     (job_full),
      .job_push     (job_push),
      .job_data     (job_in_data),
      .bank_release (bank_release),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   // Decouples string completion from response replay.
   fdx_job_queue u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job_in_data),
      .full       (job_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_job   (job_head)
   );

   // Back end: field memory and response beats.
   fdx_back #(
      .DELIM_MAX (DELIM_MAX),
      .FIELD_MAX (FIELD_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .job_valid    (job_valid),
      .job_data     (job_head),
      .job_pop      (job_pop),
      .bank_release (bank_release),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule

>>> hw/rtl/fdx_checker.sv
// Port-level checks on the delimited field extractor, bound to its top level.
// Depends on fdx_pkg and delimited_field_extractor_top_assert.svh.
`include "delimited_field_extractor_top_assert.svh"

module fdx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input fdx_pkg::rsp_type rsp_data
);
   import fdx_pkg::*;

   // A waiting response beat stays put until it is popped.
   `FDX_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

   // Coming out of a reset edge the block is empty and ready for bytes.
   `FDX_ASSERT_ALWAYS(a_reset_clean, clock, reset, rsp_empty && !req_full)

   // Field bytes and their status come out back to back.
   `FDX_ASSERT_NEXT(a_field_burst, clock, reset, !rsp_empty && rsp_pop && !rsp_data.result_type, !rsp_empty)

   // Only a status beat closes a run, and field bytes carry no failure.
   `FDX_ASSERT_IMPLY(a_beat_format, clock, reset, !rsp_empty, (rsp_data.last_of_run == rsp_data.result_type) && (rsp_data.result_type || !rsp_data.status))

endmodule

bind delimited_field_extractor_top fdx_checker u_fdx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

>>> sim/fdx_extract_checker.sv
`timescale 1ns / 100ps
// Beat checker for the delimited field extractor: watches the request, response
// and register ports, predicts every response beat and compares them in order.
// Depends on fdx_pkg only.
module fdx_extract_checker #(
   parameter int DELIM_MAX = 8,
   parameter int FIELD_MAX = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  fdx_pkg::req_type               req_data,
   input  logic                           rsp_pop,
   input  logic                           rsp_empty,
   input  fdx_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [fdx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fdx_pkg::CFG_W-1:0]      pwdata,
   output int                             mismatch_count,
   output int                             beats_outstanding
);
   import fdx_pkg::*;

   localparam int   BUF_DEPTH     = FIELD_MAX + DELIM_MAX;
   localparam int   REPORT_LIMIT  = 10;
   localparam logic RESULT_FIELD  = 1'b0;
   localparam logic RESULT_STATUS = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_FAIL   = 1'b1;

   typedef enum logic [1:0] {SEEKING, COLLECTING, FINISHED} scan_phase_type;

   cfg_type        cfg;
   scan_phase_type phase;
   logic [63:0]    recent;
   logic [3:0]     seen;
   logic [7:0]     field_buf [BUF_DEPTH];
   int             collected;
   rsp_type        due_beats [$];
   rsp_type        step_beats [$];
   int             mismatches;

   function automatic rsp_type make_beat(logic kind, logic [7:0] value, logic st);
      rsp_type beat;
      beat.result_type = kind;
      beat.field_byte  = value;
      beat.status      = st;
      beat.last_of_run = 1'b0;
      return beat;
   endfunction

   function automatic void clear_window();
      recent = '0;
      seen   = '0;
   endfunction

   function automatic void shift_in(logic [7:0] b);
      recent = {b, recent[63:8]};
      if (seen < 4'd8) seen++;
   endfunction

   // True when the newest len bytes equal the low len bytes of pat.
   function automatic bit window_match(logic [63:0] pat, int len);
      logic [63:0] mask;
      if (len == 0 || len > DELIM_MAX || len > 8 || seen < len) return 1'b0;
      mask = {64{1'b1}} >> (64 - 8 * len);
      return ((recent >> (64 - 8 * len)) & mask) == (pat & mask);
   endfunction

   function automatic void enter_collect();
      phase     = COLLECTING;
      collected = 0;
      clear_window();
   endfunction

   function automatic void close_field(int len, bit ok);
      if (ok) begin
         for (int i = 0; i < len && i < BUF_DEPTH; i++)
            step_beats.push_back(make_beat(RESULT_FIELD, field_buf[i], STATUS_OK));
         step_beats.push_back(make_beat(RESULT_STATUS, 8'h00, STATUS_OK));
      end else begin
         step_beats.push_back(make_beat(RESULT_STATUS, 8'h00, STATUS_FAIL));
      end
      phase = FINISHED;
   endfunction

   function automatic void collect_byte(logic [7:0] b);
      int n;
      int maxlen;
      int el;
      int len;
      maxlen = (cfg.max_field_length > FIELD_MAX) ? FIELD_MAX : cfg.max_field_length;
      el     = cfg.end_length;
      if (collected < BUF_DEPTH) begin
         field_buf[collected] = b;
         collected++;
      end
      shift_in(b);
      n = collected;
      if (el > DELIM_MAX) return;
      if (window_match(cfg.end_pattern, el)) begin
         len = n - el;
         close_field(len, len <= maxlen);
      end else if (n + 1 > maxlen + el || n >= BUF_DEPTH) begin
         close_field(0, 1'b0);
      end
   endfunction

   function automatic void extract_byte(logic [7:0] b, logic last);
      bit      taken;
      rsp_type tail;
      taken = 1'b0;
      step_beats.delete();
      if (phase == SEEKING) begin
         if (cfg.start_length == 0) begin
            enter_collect();
         end else begin
            shift_in(b);
            taken = 1'b1;
            if (window_match(cfg.start_pattern, cfg.start_length)) enter_collect();
         end
      end
      if (phase == COLLECTING) begin
         if (cfg.end_length == 0) close_field(0, 1'b1);
         else if (!taken) collect_byte(b);
      end
      if (last) begin
         if (step_beats.size() == 0 && phase != FINISHED) close_field(0, 1'b0);
         phase     = SEEKING;
         collected = 0;
         clear_window();
      end
      if (step_beats.size() > 0) begin
         tail = step_beats.pop_back();
         tail.last_of_run = 1'b1;
         step_beats.push_back(tail);
      end
      foreach (step_beats[i]) due_beats.push_back(step_beats[i]);
   endfunction

   function automatic void store_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
         REG_START_PATTERN: cfg.start_pattern    = value;
         REG_START_LENGTH:  cfg.start_length     = value[3:0];
         REG_END_PATTERN:   cfg.end_pattern      = value;
         REG_END_LENGTH:    cfg.end_length       = value[3:0];
         REG_MAX_FIELD:     cfg.max_field_length = value[5:0];
         default: ;
      endcase
   endfunction

   function automatic void check_beat(rsp_type got);
      rsp_type want;
      if (due_beats.size() == 0) begin
         if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected beat type=%0d byte=%02h status=%0d last=%0d",
                     $realtime, got.result_type, got.field_byte, got.status,
                     got.last_of_run);
         mismatches++;
      end else begin
         want = due_beats.pop_front();
         if (got.result_type !== want.result_type || got.field_byte !== want.field_byte ||
             got.status !== want.status || got.last_of_run !== want.last_of_run) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: beat mismatch exp type=%0d byte=%02h status=%0d last=%0d, got type=%0d byte=%02h status=%0d last=%0d",
                        $realtime, want.result_type, want.field_byte, want.status,
                        want.last_of_run, got.result_type, got.field_byte, got.status,
                        got.last_of_run);
            mismatches++;
         end
      end
   endfunction

   // Response beats are compared before the request beat of the same edge is
   // predicted, and register writes land last, so a beat accepted together
   // with a write still sees the old settings.
   always @(posedge clock) begin
      if (reset) begin
         cfg.start_pattern    = '0;
         cfg.start_length     = '0;
         cfg.end_pattern      = '0;
         cfg.end_length       = '0;
         cfg.max_field_length = MAX_FIELD_RESET;
         phase                = SEEKING;
         collected            = 0;
         mismatches           = 0;
         clear_window();
         due_beats.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_beat(rsp_data);
         if (req_push && !req_full) extract_byte(req_data.data_byte, req_data.is_last);
         if (psel && penable && pwrite && pready)
            store_reg(paddr[CSR_ADDR_W-1:3], pwdata);
      end
      mismatch_count    <= mismatches;
      beats_outstanding <= due_beats.size();
   end

endmodule

>>> sim/tb_delimited_field_extractor_top.sv
`timescale 1ns / 100ps
// Testbench top for the delimited field extractor: drives strings, register
// writes and response stalls, and gives the verdict. Depends on fdx_pkg, the
// block's RTL and fdx_extract_checker.
module tb_delimited_field_extractor_top;
   import fdx_pkg::*;

   localparam int DELIM_MAX     = 8;
   localparam int FIELD_MAX     = 32;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BYTES  = 105;

   localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
   localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
   localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
   localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'

   typedef logic [7:0] text_type [$];

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   req_type               req_data  = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CFG_W-1:0]      pwdata    = '0;
   logic [CFG_W-1:0]      prdata;
   logic                  pready;

   int send_idle_pct = 21;
   int recv_idle_pct = 84;
   int bytes_sent    = 0;
   int stall_cycles  = 0;
   int mismatch_count;
   int beats_outstanding;

   // Settings currently loaded, so random strings can carry the delimiters.
   logic [63:0] cur_start_pat = '0;
   int          cur_start_len = 0;
   logic [63:0] cur_end_pat   = '0;
   int          cur_end_len   = 0;
   int          cur_max_len   = 32;

   always #6 clock = ~clock;

   delimited_field_extractor_top #(
      .DELIM_MAX (DELIM_MAX),
      .FIELD_MAX (FIELD_MAX)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fdx_extract_checker #(
      .DELIM_MAX (DELIM_MAX),
      .FIELD_MAX (FIELD_MAX)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data          (req_data),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_data          (rsp_data),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .mismatch_count    (mismatch_count),
      .beats_outstanding (beats_outstanding)
   );

   // The receiver decides afresh every cycle whether it takes a beat, so its
   // stalls fall on every phase of a field replay.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: any accepted beat on either channel restarts the count. A hang
   // anywhere ends the run with the failure verdict.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offers one source byte and returns at the edge where it was taken. The
   // push stays high on return, so back-to-back beats need no second write
   // to the same signal in one step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= req_type'{data_byte: b, is_last: last};
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_text(input text_type text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Holds the sender until every predicted beat has come out, then lets the front
   // end settle: a byte that causes no beat may still be in flight when the last
   // beat leaves. The first edge lets the checker count the final request beat
   // before we look at its tally.
   task automatic wait_until_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (beats_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands when pready is seen high.
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_setup(input logic [63:0] sp, input int sl, input logic [63:0] ep,
                             input int el, input int mx);
      write_reg(REG_START_PATTERN, sp);
      write_reg(REG_START_LENGTH, 64'(sl));
      write_reg(REG_END_PATTERN, ep);
      write_reg(REG_END_LENGTH, 64'(el));
      write_reg(REG_MAX_FIELD, 64'(mx));
      cur_start_pat = sp;
      cur_start_len = sl;
      cur_end_pat   = ep;
      cur_end_len   = el;
      cur_max_len   = mx;
   endtask

   // Mostly a small alphabet so that delimiters and stray partial matches
   // are common, otherwise any byte value.
   function automatic logic [7:0] text_char();
      if ($urandom_range(3) == 0) return 8'($urandom_range(255));
      return 8'h41 + 8'($urandom_range(3));
   endfunction

   task automatic pick_random_setup();
      logic [63:0] sp;
      logic [63:0] ep;
      int          sl;
      int          el;
      int          mx;
      for (int i = 0; i < 8; i++) begin
         sp[8*i +: 8] = text_char();
         ep[8*i +: 8] = text_char();
      end
      sl = $urandom_range(0, 8);
      if ($urandom_range(7) == 0) sl = $urandom_range(9, 15);
      el = $urandom_range(0, 8);
      if ($urandom_range(7) == 0) el = $urandom_range(9, 15);
      mx = ($urandom_range(4) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
      load_setup(sp, sl, ep, el, mx);
   endtask

   // Most strings are well formed: noise, start delimiter, a field of random
   // bytes, end delimiter, a little trailing noise. Some are pure noise and
   // some lose their end delimiter.
   function automatic text_type make_random_text();
      text_type t;
      int       eff_max;
      int       field_len;
      bit       drop_end;
      drop_end = ($urandom_range(5) == 0);
      repeat ($urandom_range(0, 3)) t.push_back(text_char());
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 6)) t.push_back(text_char());
         return t;
      end
      if (cur_start_len <= 8)
         for (int i = 0; i < cur_start_len; i++) t.push_back(cur_start_pat[8*i +: 8]);
      eff_max   = (cur_max_len > FIELD_MAX) ? FIELD_MAX : cur_max_len;
      field_len = ($urandom_range(5) == 0) ? $urandom_range(0, eff_max + 2)
                                           : $urandom_range(0, 6);
      repeat (field_len) t.push_back(8'($urandom_range(255)));
      if (cur_end_len <= 8 && !drop_end)
         for (int i = 0; i < cur_end_len; i++) t.push_back(cur_end_pat[8*i +: 8]);
      repeat ($urandom_range(0, 2)) t.push_back(text_char());
      if (t.size() == 0) t.push_back(text_char());
      return t;
   endfunction

   initial begin
      int random_start;
      int strings_done;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: both delimiters empty, so the string succeeds at
      // once with an empty field.
      send_text('{8'hFF});

      // Single-character delimiters; the field holds the byte extremes and
      // the byte after the success status is ignored.
      wait_until_idle();
      load_setup(64'(CH_LT), 1, 64'(CH_GT), 1, 32);
      send_text('{CH_LT, 8'h00, 8'hFF, CH_GT, 8'h7A});

      // Two-byte delimiters with a tiny maximum: the field overruns and the
      // failure comes out before the string ends.
      wait_until_idle();
      load_setup(64'({CH_LBRACE, CH_LBRACE}), 2, 64'({CH_RBRACE, CH_RBRACE}), 2, 2);
      send_text('{CH_LBRACE, CH_LBRACE, 8'h61, 8'h62, 8'h63, 8'h64, 8'h78});

      // Start delimiter longer than the hardware allows: never found, so the
      // failure waits for the last byte.
      wait_until_idle();
      load_setup(64'h0, 9, 64'(CH_GT), 1, 32);
      send_text('{8'h61, 8'h62});

      // Zero maximum still accepts an empty field.
      wait_until_idle();
      load_setup(64'(CH_LT), 1, 64'(CH_GT), 1, 0);
      send_text('{CH_LT, CH_GT});

      // Maximum lowered in the middle of a string: the next field byte
      // already makes the field too long.
      wait_until_idle();
      load_setup(64'(CH_LT), 1, 64'(CH_GT), 1, 32);
      send_byte(CH_LT, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      wait_until_idle();
      write_reg(REG_MAX_FIELD, 64'd1);
      cur_max_len = 1;
      send_byte(8'h63, 1'b0);
      send_byte(CH_GT, 1'b1);

      // Random part, opening with the widest delimiters and a maximum above
      // the bound. Every second string the settings change, which also
      // holds the sender until the block has drained.
      wait_until_idle();
      load_setup({64{1'b1}}, 8, 64'h0, 8, 63);
      random_start = bytes_sent;
      strings_done = 0;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         if (bytes_sent - random_start < 35) begin
            send_idle_pct = 21;
            recv_idle_pct = 84;
         end else if (bytes_sent - random_start < 70) begin
            send_idle_pct = 84;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (strings_done % 2 == 1) begin
            wait_until_idle();
            pick_random_setup();
         end
         send_text(make_random_text());
         strings_done++;
      end

      wait_until_idle();
      if (mismatch_count == 0 && beats_outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
